// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked through reset as well.
`define ASSERT_NEXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/bmqa_pkg.sv =====
// Types, constants and tables of the bone morph quaternion accumulator.
package bmqa_pkg;

  localparam int BONES  = 512;
  localparam int BONE_W = (BONES > 1) ? $clog2(BONES) : 1;

  localparam logic REQ_CLEAR = 1'b0;
  localparam logic REQ_ACC   = 1'b1;

  localparam logic signed [31:0] ANG_PI          = 32'sd52707179;
  localparam logic signed [31:0] ANG_HALF_PI     = 32'sd26353589;
  localparam logic signed [31:0] ANG_TWO_PI      = 32'sd105414357;
  localparam logic signed [31:0] ANG_QUIRK       = 32'sd52680460;
  localparam logic signed [35:0] CORDIC_GAIN_INV = 36'sd163008219;
  localparam logic signed [15:0] Q14_ONE         = 16'sd16384;
  localparam logic [31:0]        Q28_ONE         = 32'd268435456;

  // q operand index of each Hamilton product term, term t at bits [2t+1:2t]
  localparam logic [31:0] QIDX_TAB = 32'b10_01_00_11_11_00_01_10_00_11_10_01_01_10_11_00;
  // terms that subtract
  localparam logic [15:0] QNEG_TAB = 16'b1110_0100_0010_1000;

  typedef struct packed {
    logic               req_type;
    logic [8:0]         bone_index;
    logic signed [31:0] move_x;
    logic signed [31:0] move_y;
    logic signed [31:0] move_z;
    logic signed [15:0] turn_x;
    logic signed [15:0] turn_y;
    logic signed [15:0] turn_z;
    logic signed [15:0] turn_w;
    logic signed [15:0] weight;
  } in_t;

  typedef struct packed {
    logic [8:0]         out_bone;
    logic signed [15:0] acc_rot_x;
    logic signed [15:0] acc_rot_y;
    logic signed [15:0] acc_rot_z;
    logic signed [15:0] acc_rot_w;
    logic signed [31:0] acc_pos_x;
    logic signed [31:0] acc_pos_y;
    logic signed [31:0] acc_pos_z;
  } out_t;

  typedef struct packed {
    logic               valid;
    logic signed [15:0] rot_w;
    logic signed [15:0] rot_z;
    logic signed [15:0] rot_y;
    logic signed [15:0] rot_x;
    logic signed [31:0] pos_z;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_x;
  } rec_t;

  function automatic logic signed [31:0] atan_step(input logic [4:0] i);
    logic signed [31:0] r;
    unique case (i)
      5'd0: r = 32'sd13176795;
      5'd1: r = 32'sd7778716;
      5'd2: r = 32'sd4110060;
      5'd3: r = 32'sd2086331;
      5'd4: r = 32'sd1047214;
      5'd5: r = 32'sd524117;
      5'd6: r = 32'sd262123;
      5'd7: r = 32'sd131069;
      5'd8: r = 32'sd65536;
      default: r = 32'sd1 <<< (5'd24 - i);
    endcase
    return r;
  endfunction

endpackage

// ===== sv/bone_morph_quaternion_accumulator_top.sv =====
// Top level of the bone morph quaternion accumulator.
// One request at a time: start is taken while busy is low. An accumulate
// runs the shared square-root, CORDIC and divider iterations under one
// sequencer and one 36x18 multiplier (an entry rotation that reduces to
// identity skips the scaling, rotation and division steps); it returns one
// result on result with done high for a single cycle, which the receiver must
// take then. A clear returns nothing and sweeps every record memory entry;
// the same sweep runs after reset, and busy stays high until it ends.
module bone_morph_quaternion_accumulator_top import bmqa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  in_t  request,
  output logic done,
  output out_t result
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_SWEEP = 5'd1;
  localparam logic [4:0] S_DROP  = 5'd2;
  localparam logic [4:0] S_PREP  = 5'd3;
  localparam logic [4:0] S_SQRT  = 5'd4;
  localparam logic [4:0] S_VEC   = 5'd5;
  localparam logic [4:0] S_ANG   = 5'd6;
  localparam logic [4:0] S_SCALE = 5'd7;
  localparam logic [4:0] S_MOD   = 5'd8;
  localparam logic [4:0] S_RED   = 5'd9;
  localparam logic [4:0] S_ROT   = 5'd10;
  localparam logic [4:0] S_QW    = 5'd11;
  localparam logic [4:0] S_SS    = 5'd12;
  localparam logic [4:0] S_MULQ  = 5'd13;
  localparam logic [4:0] S_DIV   = 5'd14;
  localparam logic [4:0] S_QUAT  = 5'd15;
  localparam logic [4:0] S_TRANS = 5'd16;
  localparam logic [4:0] S_DONE  = 5'd17;

  logic [4:0]         state;
  logic [4:0]         cnt;
  logic [BONE_W-1:0]  idx;
  in_t                req_r;
  logic signed [15:0] twc;
  logic signed [35:0] x, y;
  logic signed [31:0] z, ang_r;
  logic [59:0]        v, res, bitr;
  logic [30:0]        len;
  logic signed [53:0] prodr;
  logic signed [39:0] acc;
  logic [50:0]        rem;
  logic [19:0]        quot;
  logic               neg, flip, sq_len;
  logic [1:0]         qi;
  logic signed [17:0] q [4];
  logic signed [15:0] rot_r [4];
  logic signed [31:0] pos_r [3];
  logic               neg_d, last_d;
  logic [1:0]         kd;
  out_t               out_r;
  logic               done_r;

  rec_t               mem [BONES];
  rec_t               rd;
  rec_t               wdata;
  logic               we;
  logic [BONE_W-1:0]  waddr, raddr;

  logic signed [15:0] tr_a [3];
  logic signed [31:0] mv_a [3];
  logic signed [15:0] av [4];
  logic signed [31:0] pa [3];
  logic signed [35:0] ma;
  logic signed [17:0] mb;
  logic signed [53:0] mul;

  logic [59:0]        sq_sum, v_nx, res_nx;
  logic               sq_ge;
  logic               cw;
  logic signed [35:0] xs, ys, x_nx, y_nx;
  logic signed [31:0] at, z_nx;
  logic [50:0]        d_sh;
  logic               div_ge;
  logic [19:0]        quot_nx;
  logic signed [35:0] xi, yi, cs;
  logic signed [31:0] ang_v, red1, sc_ang;
  logic signed [39:0] qsum, qrnd;
  logic signed [53:0] ptr;
  logic signed [36:0] tsum;
  logic [1:0]         ti;
  logic signed [53:0] pabs;

  assign busy   = (state != S_IDLE);
  assign done   = done_r;
  assign result = out_r;

  always_comb begin
    tr_a[0] = req_r.turn_x;
    tr_a[1] = req_r.turn_y;
    tr_a[2] = req_r.turn_z;
    mv_a[0] = req_r.move_x;
    mv_a[1] = req_r.move_y;
    mv_a[2] = req_r.move_z;
    if (rd.valid) begin
      av[0] = rd.rot_x;
      av[1] = rd.rot_y;
      av[2] = rd.rot_z;
      av[3] = rd.rot_w;
      pa[0] = rd.pos_x;
      pa[1] = rd.pos_y;
      pa[2] = rd.pos_z;
    end else begin
      av[0] = '0;
      av[1] = '0;
      av[2] = '0;
      av[3] = Q14_ONE;
      pa[0] = '0;
      pa[1] = '0;
      pa[2] = '0;
    end
  end

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      S_PREP: begin
        ma = 36'(twc);
        mb = 18'(twc);
      end
      S_SCALE: begin
        ma = 36'(ang_r);
        mb = 18'(req_r.weight);
      end
      S_SS: begin
        if (cnt < 5'd3) begin
          ma = 36'(tr_a[cnt[1:0]]);
          mb = 18'(tr_a[cnt[1:0]]);
        end
      end
      S_MULQ: begin
        if (qi < 2'd3) begin
          ma = y;
          mb = 18'(tr_a[qi]);
        end
      end
      S_QUAT: begin
        if (cnt < 5'd16) begin
          ma = 36'(av[cnt[1:0] + 2'd3]);
          mb = q[QIDX_TAB[{cnt[3:0], 1'b0} +: 2]];
        end
      end
      S_TRANS: begin
        if (cnt < 5'd3) begin
          ma = 36'(mv_a[cnt[1:0]]);
          mb = 18'(req_r.weight);
        end
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign mul = 54'(ma) * 54'(mb);

  // square root step
  always_comb begin
    sq_sum = res + bitr;
    sq_ge  = (v >= sq_sum);
    v_nx   = sq_ge ? v - sq_sum : v;
    res_nx = sq_ge ? (res >> 1) + bitr : (res >> 1);
  end

  // CORDIC step
  always_comb begin
    cw   = (state == S_VEC) ? (y > 36'sd0) : (z < 32'sd0);
    xs   = x >>> cnt;
    ys   = y >>> cnt;
    at   = atan_step(cnt);
    x_nx = cw ? x + ys : x - ys;
    y_nx = cw ? y - xs : y + xs;
    z_nx = cw ? z + at : z - at;
  end

  // divider step
  always_comb begin
    d_sh    = 51'(len) << (5'd19 - cnt);
    div_ge  = (rem >= d_sh);
    quot_nx = {quot[18:0], div_ge};
  end

  always_comb begin
    xi     = 36'(twc) <<< 14;
    yi     = 36'(res_nx);
    cs     = flip ? -x : x;
    ang_v  = (twc < 16'sd0) ? z - ANG_QUIRK : z;
    sc_ang = 32'((prodr + 54'sd2048) >>> 12);
    red1   = (z > ANG_PI) ? z - ANG_TWO_PI : z;
    qsum   = acc + 40'(neg_d ? -prodr : prodr);
    qrnd   = (qsum + 40'sd8192) >>> 14;
    ti     = cnt[1:0] - 2'd1;
    ptr    = (prodr + 54'sd2048) >>> 12;
    tsum   = 37'(pa[ti]) + 37'(ptr);
    pabs   = (prodr < 54'sd0) ? -prodr : prodr;
  end

  always_comb begin
    raddr = BONE_W'(req_r.bone_index);
    we    = (state == S_SWEEP) || (state == S_DONE);
    waddr = (state == S_SWEEP) ? idx : raddr;
    wdata.valid = (state == S_DONE);
    wdata.rot_x = rot_r[0];
    wdata.rot_y = rot_r[1];
    wdata.rot_z = rot_r[2];
    wdata.rot_w = rot_r[3];
    wdata.pos_x = pos_r[0];
    wdata.pos_y = pos_r[1];
    wdata.pos_z = pos_r[2];
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    prodr  <= mul;
    neg_d  <= QNEG_TAB[cnt[3:0]];
    last_d <= (cnt[1:0] == 2'd3);
    kd     <= cnt[3:2];
    if (rst) begin
      state  <= S_SWEEP;
      idx    <= '0;
      cnt    <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (state == S_DONE);
      unique case (state)
        S_IDLE: begin
          if (start) begin
            req_r <= request;
            if (request.turn_w > Q14_ONE) begin
              twc <= Q14_ONE;
            end else if (request.turn_w < -Q14_ONE) begin
              twc <= -Q14_ONE;
            end else begin
              twc <= request.turn_w;
            end
            cnt <= '0;
            if (request.req_type == REQ_CLEAR) begin
              idx   <= '0;
              state <= S_SWEEP;
            end else if (32'(request.bone_index) < BONES) begin
              state <= S_PREP;
            end else begin
              state <= S_DROP;
            end
          end
        end
        S_SWEEP: begin
          idx <= idx + 1'b1;
          if (idx == BONE_W'(BONES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_DROP: begin
          state <= S_IDLE;
        end
        S_PREP: begin
          if (cnt == 5'd1) begin
            v      <= {Q28_ONE - prodr[31:0], 28'b0};
            res    <= '0;
            bitr   <= 60'd1 << 58;
            sq_len <= 1'b0;
            cnt    <= '0;
            state  <= S_SQRT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_SQRT: begin
          v    <= v_nx;
          res  <= res_nx;
          bitr <= bitr >> 2;
          cnt  <= cnt + 1'b1;
          if (cnt == 5'd29) begin
            cnt <= '0;
            if (sq_len) begin
              len   <= res_nx[30:0];
              qi    <= '0;
              state <= S_MULQ;
            end else if (res_nx == '0) begin
              z     <= (twc > 16'sd0) ? 32'sd0 : ANG_PI;
              state <= S_ANG;
            end else begin
              if (twc < 16'sd0) begin
                x <= yi;
                y <= -xi;
                z <= ANG_HALF_PI;
              end else begin
                x <= xi;
                y <= yi;
                z <= '0;
              end
              state <= S_VEC;
            end
          end
        end
        S_VEC, S_ROT: begin
          x   <= x_nx;
          y   <= y_nx;
          z   <= z_nx;
          cnt <= cnt + 1'b1;
          if (cnt == 5'd23) begin
            cnt   <= '0;
            state <= (state == S_VEC) ? S_ANG : S_QW;
          end
        end
        S_ANG: begin
          ang_r <= ang_v;
          cnt   <= '0;
          if (ang_v == 32'sd0 ||
              (req_r.turn_x == 16'sd0 && req_r.turn_y == 16'sd0 && req_r.turn_z == 16'sd0)) begin
            q[0]  <= '0;
            q[1]  <= '0;
            q[2]  <= '0;
            q[3]  <= 18'(Q14_ONE);
            acc   <= '0;
            state <= S_QUAT;
          end else begin
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          if (cnt == 5'd1) begin
            z     <= sc_ang + (ANG_TWO_PI <<< 3);
            cnt   <= '0;
            state <= S_MOD;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_MOD: begin
          if (z >= (ANG_TWO_PI <<< (2'd3 - cnt[1:0]))) begin
            z <= z - (ANG_TWO_PI <<< (2'd3 - cnt[1:0]));
          end
          cnt <= cnt + 1'b1;
          if (cnt == 5'd3) begin
            cnt   <= '0;
            state <= S_RED;
          end
        end
        S_RED: begin
          if (red1 > ANG_HALF_PI) begin
            z    <= ANG_PI - red1;
            flip <= 1'b1;
          end else if (red1 < -ANG_HALF_PI) begin
            z    <= -ANG_PI - red1;
            flip <= 1'b1;
          end else begin
            z    <= red1;
            flip <= 1'b0;
          end
          x     <= CORDIC_GAIN_INV;
          y     <= '0;
          cnt   <= '0;
          state <= S_ROT;
        end
        S_QW: begin
          q[3]  <= 18'((cs + 36'sd8192) >>> 14);
          acc   <= '0;
          cnt   <= '0;
          state <= S_SS;
        end
        S_SS: begin
          cnt <= cnt + 1'b1;
          if (cnt != 5'd0) begin
            acc <= acc + 40'(prodr);
          end
          if (cnt == 5'd3) begin
            v      <= {32'(acc + 40'(prodr)), 28'b0};
            res    <= '0;
            bitr   <= 60'd1 << 58;
            sq_len <= 1'b1;
            cnt    <= '0;
            state  <= S_SQRT;
          end
        end
        S_MULQ: begin
          if (cnt == 5'd1) begin
            neg   <= (prodr < 54'sd0);
            rem   <= 51'(pabs) + 51'(len >> 1);
            quot  <= '0;
            cnt   <= '0;
            state <= S_DIV;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DIV: begin
          if (div_ge) begin
            rem <= rem - d_sh;
          end
          quot <= quot_nx;
          cnt  <= cnt + 1'b1;
          if (cnt == 5'd19) begin
            q[qi] <= neg ? -18'(quot_nx) : 18'(quot_nx);
            cnt   <= '0;
            if (qi == 2'd2) begin
              acc   <= '0;
              state <= S_QUAT;
            end else begin
              qi    <= qi + 1'b1;
              state <= S_MULQ;
            end
          end
        end
        S_QUAT: begin
          cnt <= cnt + 1'b1;
          if (cnt != 5'd0) begin
            if (last_d) begin
              acc <= '0;
              if (qrnd > 40'sd32767) begin
                rot_r[kd] <= 16'sd32767;
              end else if (qrnd < -40'sd32768) begin
                rot_r[kd] <= 16'sh8000;
              end else begin
                rot_r[kd] <= 16'(qrnd);
              end
            end else begin
              acc <= qsum;
            end
          end
          if (cnt == 5'd16) begin
            cnt   <= '0;
            state <= S_TRANS;
          end
        end
        S_TRANS: begin
          cnt <= cnt + 1'b1;
          if (cnt != 5'd0) begin
            if (tsum > 37'sd2147483647) begin
              pos_r[ti] <= 32'sh7fffffff;
            end else if (tsum < -37'sd2147483648) begin
              pos_r[ti] <= 32'sh80000000;
            end else begin
              pos_r[ti] <= 32'(tsum);
            end
          end
          if (cnt == 5'd3) begin
            cnt   <= '0;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          out_r.out_bone  <= req_r.bone_index;
          out_r.acc_rot_x <= rot_r[0];
          out_r.acc_rot_y <= rot_r[1];
          out_r.acc_rot_z <= rot_r[2];
          out_r.acc_rot_w <= rot_r[3];
          out_r.acc_pos_x <= pos_r[0];
          out_r.acc_pos_y <= pos_r[1];
          out_r.acc_pos_z <= pos_r[2];
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/bmqa_checker.sv =====
// Port-level checker for the bone morph quaternion accumulator, with its bind.
`include "assert_macros.svh"

module bmqa_checker import bmqa_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input in_t  request,
  input logic done
);

  logic req_seen;

  assign req_seen = start && !busy && (request.req_type == REQ_ACC || request.req_type == REQ_CLEAR);

  `ASSERT_NEXT_ALWAYS(a_reset_sweeps, rst, busy)
  `ASSERT_NEXT(a_accept_busy, req_seen, busy && !done)
  `ASSERT_NEXT(a_done_single, done, !done)
  `ASSERT_IMPL(a_done_idle, done, !busy && $past(busy))

endmodule

bind bone_morph_quaternion_accumulator_top bmqa_checker u_chk (.*);

// ===== sim/tb_bone_morph_quaternion_accumulator_top.sv =====
// Self-checking testbench for the bone morph quaternion accumulator: random and directed requests.
`timescale 1ns / 100ps

module tb_bone_morph_quaternion_accumulator_top;
  import bmqa_pkg::*;

  localparam int  CYCLE_LIMIT = 600000;
  localparam int  DRAIN_CYCLES = 300;
  localparam longint PI_Q24 = 52707179;
  localparam longint HALF_PI_Q24 = 26353589;
  localparam longint TWO_PI_Q24 = 105414357;
  localparam longint QUIRK_Q24 = 52680460;
  localparam longint GAIN_INV_Q28 = 163008219;
  localparam longint ONE_Q14 = 16384;
  localparam longint ARCTAN_HEAD [9] = '{13176795, 7778716, 4110060, 2086331, 1047214,
                                         524117, 262123, 131069, 65536};

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic done;
  in_t  request;
  out_t result;

  bit     rec_valid [BONES];
  longint rec_rot [BONES][4];
  longint rec_pos [BONES][3];
  out_t   pending_records[$];
  int     errors;
  int     cycles;
  int     send_idle_pct;

  bone_morph_quaternion_accumulator_top i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .done(done),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic longint arctan_step(int i);
    if (i < 9) return ARCTAN_HEAD[i];
    return longint'(1) << (24 - i);
  endfunction

  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = longint'(1) << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint arccos_q24(longint w);
    longint x, y, z, t, nx, ny, sq;
    z = 0;
    sq = int_sqrt(longint'(ONE_Q14 * ONE_Q14 - w * w) << 28);
    if (sq == 0) return w > 0 ? 0 : PI_Q24;
    x = w * 16384;
    y = sq;
    if (x < 0) begin
      t = x;
      x = y;
      y = -t;
      z = HALF_PI_Q24;
    end
    for (int i = 0; i < 24; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += arctan_step(i);
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= arctan_step(i);
      end
      x = nx;
      y = ny;
    end
    return z;
  endfunction

  function automatic void sin_cos_q28(longint a, output longint s, output longint c);
    longint r, x, y, nx, ny;
    bit flip;
    r = a % TWO_PI_Q24;
    x = GAIN_INV_Q28;
    y = 0;
    flip = 0;
    if (r < 0) r += TWO_PI_Q24;
    if (r > PI_Q24) r -= TWO_PI_Q24;
    if (r > HALF_PI_Q24) begin
      r = PI_Q24 - r;
      flip = 1;
    end else if (r < -HALF_PI_Q24) begin
      r = -PI_Q24 - r;
      flip = 1;
    end
    for (int i = 0; i < 24; i++) begin
      if (r >= 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        r -= arctan_step(i);
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        r += arctan_step(i);
      end
      x = nx;
      y = ny;
    end
    s = y;
    c = flip ? -x : x;
  endfunction

  function automatic longint div_half_away(longint num, longint den);
    longint m;
    m = num < 0 ? -num : num;
    m = (m + den / 2) / den;
    return num < 0 ? -m : m;
  endfunction

  // Apply one accumulate to the record copy and return the updated record.
  function automatic out_t accumulate_record(in_t r);
    longint mv[3], tr[3], q[4], a[4], p[4], tw, wt, ang, sn, cs, len;
    int b;
    out_t o;
    b = r.bone_index;
    mv[0] = r.move_x; mv[1] = r.move_y; mv[2] = r.move_z;
    tr[0] = r.turn_x; tr[1] = r.turn_y; tr[2] = r.turn_z;
    tw = clamp(longint'(r.turn_w), -ONE_Q14, ONE_Q14);
    wt = r.weight;
    ang = arccos_q24(tw);
    if (tw < 0) ang -= QUIRK_Q24;
    if (ang == 0 || (tr[0] == 0 && tr[1] == 0 && tr[2] == 0)) begin
      q = '{0, 0, 0, ONE_Q14};
    end else begin
      len = int_sqrt(longint'(tr[0] * tr[0] + tr[1] * tr[1] + tr[2] * tr[2]) << 28);
      sin_cos_q28(round_shift(ang * wt, 12), sn, cs);
      for (int k = 0; k < 3; k++) q[k] = div_half_away(sn * tr[k], len);
      q[3] = round_shift(cs, 14);
    end
    if (rec_valid[b]) begin
      for (int k = 0; k < 4; k++) a[k] = rec_rot[b][k];
    end else begin
      a = '{0, 0, 0, ONE_Q14};
      for (int k = 0; k < 3; k++) rec_pos[b][k] = 0;
    end
    p[0] = a[3] * q[0] + a[0] * q[3] + a[1] * q[2] - a[2] * q[1];
    p[1] = a[3] * q[1] - a[0] * q[2] + a[1] * q[3] + a[2] * q[0];
    p[2] = a[3] * q[2] + a[0] * q[1] - a[1] * q[0] + a[2] * q[3];
    p[3] = a[3] * q[3] - a[0] * q[0] - a[1] * q[1] - a[2] * q[2];
    for (int k = 0; k < 4; k++) rec_rot[b][k] = clamp(round_shift(p[k], 14), -32768, 32767);
    for (int k = 0; k < 3; k++)
      rec_pos[b][k] = clamp(rec_pos[b][k] + round_shift(mv[k] * wt, 12),
                            -64'sd2147483648, 64'sd2147483647);
    rec_valid[b] = 1;
    o.out_bone  = r.bone_index;
    o.acc_rot_x = 16'(rec_rot[b][0]);
    o.acc_rot_y = 16'(rec_rot[b][1]);
    o.acc_rot_z = 16'(rec_rot[b][2]);
    o.acc_rot_w = 16'(rec_rot[b][3]);
    o.acc_pos_x = 32'(rec_pos[b][0]);
    o.acc_pos_y = 32'(rec_pos[b][1]);
    o.acc_pos_z = 32'(rec_pos[b][2]);
    return o;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", field, got, want, cycles);
    errors++;
  endtask

  always @(posedge clk) begin
    out_t want;
    if (!rst && done) begin
      if (pending_records.size() == 0) begin
        report_mismatch("unexpected result", result.out_bone, -1);
      end else begin
        want = pending_records.pop_front();
        if (result.out_bone != want.out_bone)
          report_mismatch("out_bone", result.out_bone, want.out_bone);
        if (result.acc_rot_x != want.acc_rot_x)
          report_mismatch("acc_rot_x", result.acc_rot_x, want.acc_rot_x);
        if (result.acc_rot_y != want.acc_rot_y)
          report_mismatch("acc_rot_y", result.acc_rot_y, want.acc_rot_y);
        if (result.acc_rot_z != want.acc_rot_z)
          report_mismatch("acc_rot_z", result.acc_rot_z, want.acc_rot_z);
        if (result.acc_rot_w != want.acc_rot_w)
          report_mismatch("acc_rot_w", result.acc_rot_w, want.acc_rot_w);
        if (result.acc_pos_x != want.acc_pos_x)
          report_mismatch("acc_pos_x", result.acc_pos_x, want.acc_pos_x);
        if (result.acc_pos_y != want.acc_pos_y)
          report_mismatch("acc_pos_y", result.acc_pos_y, want.acc_pos_y);
        if (result.acc_pos_z != want.acc_pos_z)
          report_mismatch("acc_pos_z", result.acc_pos_z, want.acc_pos_z);
      end
    end
  end

  task automatic send_request(in_t r);
    if ($urandom_range(99) < send_idle_pct) repeat ($urandom_range(1, 12)) @(negedge clk);
    @(negedge clk);
    start = 1'b1;
    request = r;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    if (r.req_type == REQ_CLEAR) begin
      for (int k = 0; k < BONES; k++) rec_valid[k] = 0;
    end else begin
      pending_records.push_back(accumulate_record(r));
    end
    @(negedge clk);
    start = 1'b0;
  endtask

  function automatic in_t make_acc(int bone, longint mx, longint my, longint mz,
                                   int tx, int ty, int tz, int tw, int wt);
    in_t r;
    r.req_type = REQ_ACC;
    r.bone_index = 9'(bone);
    r.move_x = 32'(mx); r.move_y = 32'(my); r.move_z = 32'(mz);
    r.turn_x = 16'(tx); r.turn_y = 16'(ty); r.turn_z = 16'(tz); r.turn_w = 16'(tw);
    r.weight = 16'(wt);
    return r;
  endfunction

  function automatic in_t make_clear();
    in_t r;
    r = '0;
    r.req_type = REQ_CLEAR;
    r.bone_index = 9'($urandom);
    return r;
  endfunction

  task automatic test_angle_cases();
    send_request(make_acc(0, 65536, -65536, 0, 0, 0, 16384, 16384, 4096));
    send_request(make_acc(0, 1, 2, 3, 8000, 0, 0, 11585, 4096));
    send_request(make_acc(1, 0, 0, 0, 0, 16384, 0, -16384, 4096));
    send_request(make_acc(2, 0, 0, 0, 100, 200, 300, 32767, 2048));
    send_request(make_acc(3, 0, 0, 0, -100, 50, 7, -32768, -4096));
    send_request(make_acc(4, 0, 0, 0, 0, 0, 0, 0, 4096));
    send_request(make_acc(5, 0, 0, 0, 0, 0, 16384, 0, 0));
    send_request(make_acc(6, 0, 0, 0, 32767, 32767, 32767, -1, 32767));
    send_request(make_acc(7, 0, 0, 0, -32768, -32768, -32768, 1, -32768));
  endtask

  task automatic test_translation_saturation();
    send_request(make_acc(511, 64'sd2147483647, -64'sd2147483648, 12345, 1, 0, 0, 0, 32767));
    send_request(make_acc(511, 64'sd2147483647, -64'sd2147483648, -12345, 1, 0, 0, 0, 32767));
    send_request(make_acc(511, -64'sd2147483648, 64'sd2147483647, 0, 0, 1, 0, 0, -32768));
    send_request(make_acc(511, 64'sd2147483647, -64'sd2147483648, 0, 0, 0, 1, 0, -32768));
  endtask

  task automatic test_clear();
    send_request(make_clear());
    send_request(make_acc(0, 100, 200, 300, 0, 0, 0, 16384, 4096));
    send_request(make_acc(511, 100, 200, 300, 5000, 0, 0, 8000, 4096));
    send_request(make_clear());
    send_request(make_clear());
    send_request(make_acc(511, -7, 7, 0, 0, 5000, 0, -8000, -4096));
  endtask

  function automatic in_t random_request();
    in_t r;
    int sel;
    if ($urandom_range(99) < 3) return make_clear();
    r.req_type = REQ_ACC;
    r.bone_index = 9'(($urandom_range(99) < 70) ? $urandom_range(0, 7) : $urandom_range(0, 511));
    sel = $urandom_range(99);
    r.move_x = sel < 30 ? $urandom : $signed($urandom_range(0, 1 << 20)) - (1 << 19);
    r.move_y = sel < 30 ? $urandom : $signed($urandom_range(0, 1 << 20)) - (1 << 19);
    r.move_z = sel < 30 ? $urandom : $signed($urandom_range(0, 1 << 20)) - (1 << 19);
    sel = $urandom_range(99);
    r.turn_x = 16'(sel < 30 ? $urandom : $urandom_range(0, 32768) - 16384);
    r.turn_y = 16'(sel < 30 ? $urandom : $urandom_range(0, 32768) - 16384);
    r.turn_z = 16'(sel < 30 ? $urandom : $urandom_range(0, 32768) - 16384);
    sel = $urandom_range(99);
    if (sel < 10) r.turn_w = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
    else if (sel < 30) r.turn_w = 16'($urandom);
    else r.turn_w = 16'($urandom_range(0, 32768) - 16384);
    sel = $urandom_range(99);
    if (sel < 5) r.weight = '0;
    else if (sel < 35) r.weight = 16'($urandom);
    else r.weight = 16'($urandom_range(0, 8192) - 4096);
    return r;
  endfunction

  task automatic test_random(int count);
    for (int n = 0; n < count; n++) begin
      if (n == count / 3) send_idle_pct = 62;
      if (n == 2 * count / 3) send_idle_pct = 0;
      send_request(random_request());
    end
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    send_idle_pct = 11;
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_angle_cases();
    test_translation_saturation();
    test_clear();
    test_random(430);
    while (pending_records.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
